// File: rtl/slbm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slbm_pkg
// Shared types and constants of the serial-loaded bank mapper: configuration,
// mapper state, result transaction and register codes.
// ----------------------------------------------------------------------------
package slbm_pkg;

    // Field widths
    localparam int unsigned BANK_W  = 5;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned TICK_W  = 2;
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    // Constants of the serial load and bank derivation
    localparam logic [BANK_W-1:0] SHIFT_MARK    = 5'h10;
    localparam logic [BANK_W-1:0] PRG_MODE_BITS = 5'h0C;
    localparam logic [BANK_W-1:0] OUTER_MASK    = 5'h0F;
    localparam logic [TICK_W-1:0] MIN_GAP       = 2'd2;
    localparam int unsigned       RESET_BIT     = 7;

    // Configuration register indexes (paddr[3:2])
    typedef enum logic [1:0] {
        REG_PRG_MASK   = 2'd0,
        REG_CHR_MASK   = 2'd1,
        REG_OUTER_EN   = 2'd2,
        REG_WRAM_EN    = 2'd3
    } reg_idx_t;

    // Internal register chosen by CPU address bits 14:13
    typedef enum logic [1:0] {
        SEL_CONTROL = 2'd0,
        SEL_CHR_A   = 2'd1,
        SEL_CHR_B   = 2'd2,
        SEL_PRG     = 2'd3
    } load_sel_t;

    // Program bank modes (control bits 3:2)
    typedef enum logic [1:0] {
        PRG_32K_A   = 2'd0,
        PRG_32K_B   = 2'd1,
        PRG_FIX_LOW = 2'd2,
        PRG_FIX_HI  = 2'd3
    } prg_mode_t;

    typedef struct packed {
        logic [BANK_W-1:0] prg_bank_mask;
        logic [BANK_W-1:0] chr_bank_mask;
        logic              outer_prg_enable;
        logic              wram_bank_enable;
    } cfg_t;

    typedef struct packed {
        logic [BANK_W-1:0] serial_shift;
        logic [BANK_W-1:0] control;
        logic [BANK_W-1:0] chr_a;
        logic [BANK_W-1:0] chr_b;
        logic [BANK_W-1:0] prg;
        logic [TICK_W-1:0] ticks;
    } map_state_t;

    typedef struct packed {
        logic [1:0]        mirroring;
        logic [BANK_W-1:0] prg_bank_low;
        logic [BANK_W-1:0] prg_bank_high;
        logic [BANK_W-1:0] chr_bank_low;
        logic [BANK_W-1:0] chr_bank_high;
        logic [1:0]        wram_bank;
        logic              write_accepted;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/slbm_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slbm_regs
// APB configuration registers: bank masks and the outer / work RAM enables.
// ----------------------------------------------------------------------------
module slbm_regs
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [slbm_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [slbm_pkg::PDATA_W-1:0]     pwdata,
    output logic      [slbm_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready,
    output slbm_pkg::cfg_t                        cfg
);

    slbm_pkg::cfg_t      cfg_reg;
    slbm_pkg::reg_idx_t  idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign idx    = slbm_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write the addressed register on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prg_bank_mask    <= 5'd15;
            cfg_reg.chr_bank_mask    <= 5'd1;
            cfg_reg.outer_prg_enable <= 1'b0;
            cfg_reg.wram_bank_enable <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                slbm_pkg::REG_PRG_MASK:
                    cfg_reg.prg_bank_mask <= pwdata[slbm_pkg::BANK_W-1:0];
                slbm_pkg::REG_CHR_MASK:
                    cfg_reg.chr_bank_mask <= pwdata[slbm_pkg::BANK_W-1:0];
                slbm_pkg::REG_OUTER_EN:
                    cfg_reg.outer_prg_enable <= pwdata[0];
                slbm_pkg::REG_WRAM_EN:
                    cfg_reg.wram_bank_enable <= pwdata[0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            slbm_pkg::REG_PRG_MASK: prdata[slbm_pkg::BANK_W-1:0] = cfg_reg.prg_bank_mask;
            slbm_pkg::REG_CHR_MASK: prdata[slbm_pkg::BANK_W-1:0] = cfg_reg.chr_bank_mask;
            slbm_pkg::REG_OUTER_EN: prdata[0] = cfg_reg.outer_prg_enable;
            slbm_pkg::REG_WRAM_EN:  prdata[0] = cfg_reg.wram_bank_enable;
            default:                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/slbm_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slbm_bank
// Bank derivation: turns the mapper registers and configuration into the
// program, pattern and work RAM bank numbers of one result transaction.
// ----------------------------------------------------------------------------
module slbm_bank
(
    input  wire slbm_pkg::map_state_t  st,
    input  wire slbm_pkg::cfg_t        cfg,
    input  wire logic                  accepted,
    output slbm_pkg::result_t          res
);

    logic [slbm_pkg::BANK_W-1:0] mask;
    logic [slbm_pkg::BANK_W-1:0] outer;
    logic [slbm_pkg::BANK_W-1:0] sel;
    logic [slbm_pkg::BANK_W-1:0] plo;
    logic [slbm_pkg::BANK_W-1:0] phi;
    logic [slbm_pkg::BANK_W-2:0] chr_k;
    slbm_pkg::prg_mode_t         mode;

    // Program bank mask and 256K outer bank
    assign mask  = cfg.outer_prg_enable ? slbm_pkg::OUTER_MASK : cfg.prg_bank_mask;
    assign outer = (cfg.outer_prg_enable && st.chr_a[4]) ? slbm_pkg::SHIFT_MARK : '0;
    assign sel   = st.prg & mask;
    assign mode  = slbm_pkg::prg_mode_t'(st.control[3:2]);

    // Select program banks by mode
    always_comb
    begin
        unique case (mode)
            slbm_pkg::PRG_32K_A,
            slbm_pkg::PRG_32K_B:
            begin
                plo = outer + {sel[slbm_pkg::BANK_W-1:1], 1'b0};
                phi = plo + 5'd1;
            end
            slbm_pkg::PRG_FIX_LOW:
            begin
                plo = outer;
                phi = outer + sel;
            end
            slbm_pkg::PRG_FIX_HI:
            begin
                plo = outer + sel;
                phi = outer + mask;
            end
            default:
            begin
                plo = outer;
                phi = outer;
            end
        endcase
    end

    // 8K pattern bank pair index
    assign chr_k = st.chr_a[slbm_pkg::BANK_W-1:1]
                 & (cfg.chr_bank_mask[slbm_pkg::BANK_W-1:1] | 4'd1);

    // Assemble the result transaction
    always_comb
    begin
        res.mirroring     = st.control[1:0];
        res.prg_bank_low  = plo;
        res.prg_bank_high = phi;
        if (st.control[4])
        begin
            res.chr_bank_low  = st.chr_a & cfg.chr_bank_mask;
            res.chr_bank_high = st.chr_b & cfg.chr_bank_mask;
        end
        else
        begin
            res.chr_bank_low  = {chr_k, 1'b0};
            res.chr_bank_high = {chr_k, 1'b1};
        end
        res.wram_bank      = cfg.wram_bank_enable ? st.chr_a[3:2] : 2'd0;
        res.write_accepted = accepted;
    end

endmodule
`default_nettype wire

// File: rtl/slbm_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slbm_core
// Mapper state: serial shift register, control and bank registers and the
// write gap counter. Updates on each advancing transaction and reports the
// bank mapping after the update.
// ----------------------------------------------------------------------------
module slbm_core
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         cmd,
    input  wire logic [slbm_pkg::ADDR_W-1:0]  cpu_addr,
    input  wire logic [slbm_pkg::DATA_W-1:0]  wdata,
    input  wire slbm_pkg::cfg_t               cfg,
    output slbm_pkg::result_t                 res
);

    slbm_pkg::map_state_t        st_reg;
    slbm_pkg::map_state_t        st_next;
    logic                        accepted;
    logic [slbm_pkg::BANK_W-1:0] gathered;
    slbm_pkg::load_sel_t         load_sel;

    assign gathered = {wdata[0], st_reg.serial_shift[slbm_pkg::BANK_W-1:1]};
    assign load_sel = slbm_pkg::load_sel_t'(cpu_addr[14:13]);

    // Next mapper state for the current transaction
    always_comb
    begin
        st_next  = st_reg;
        accepted = 1'b0;
        if (!cmd)
        begin
            if (st_reg.ticks < slbm_pkg::MIN_GAP)
            begin
                st_next.ticks = st_reg.ticks + 2'd1;
            end
        end
        else if (cpu_addr[15])
        begin
            st_next.ticks = '0;
            if (st_reg.ticks >= slbm_pkg::MIN_GAP)
            begin
                accepted = 1'b1;
                if (wdata[slbm_pkg::RESET_BIT])
                begin
                    st_next.serial_shift = slbm_pkg::SHIFT_MARK;
                    st_next.control      = st_reg.control | slbm_pkg::PRG_MODE_BITS;
                end
                else if (st_reg.serial_shift[0])
                begin
                    st_next.serial_shift = slbm_pkg::SHIFT_MARK;
                    unique case (load_sel)
                        slbm_pkg::SEL_CONTROL: st_next.control = gathered;
                        slbm_pkg::SEL_CHR_A:   st_next.chr_a   = gathered;
                        slbm_pkg::SEL_CHR_B:   st_next.chr_b   = gathered;
                        slbm_pkg::SEL_PRG:     st_next.prg     = gathered;
                        default:               st_next.prg     = st_reg.prg;
                    endcase
                end
                else
                begin
                    st_next.serial_shift = gathered;
                end
            end
        end
    end

    // Hold state until the transaction advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.serial_shift <= slbm_pkg::SHIFT_MARK;
            st_reg.control      <= slbm_pkg::PRG_MODE_BITS;
            st_reg.chr_a        <= '0;
            st_reg.chr_b        <= '0;
            st_reg.prg          <= '0;
            st_reg.ticks        <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // Report the mapping after the update
    slbm_bank u_bank
    (
        .st       (st_next),
        .cfg      (cfg),
        .accepted (accepted),
        .res      (res)
    );

endmodule
`default_nettype wire

// File: rtl/serial_loaded_bank_mapper_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_unit
// Serial-loaded cartridge bank mapper: input register, mapper state update
// with bank derivation, and result register; APB configuration port.
// ----------------------------------------------------------------------------
// Timing: an accepted transaction passes through the input register and then the
//   result register, where out_valid rises; out_stall holds it in the input register.
// Throughput: one transaction per cycle while out_stall is low; the mapper state
//   update sits in a single stage between the input register and the result register.
// Reset: rst_n clears both valid flags, the mapper registers (shift register
//   to its marker bit, control to 0x0C) and the configuration defaults.
module serial_loaded_bank_mapper_unit
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Input channel
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             cmd,
    input  wire logic [slbm_pkg::ADDR_W-1:0]      cpu_addr,
    input  wire logic [slbm_pkg::DATA_W-1:0]      wdata,
    // Output channel
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [1:0]                            mirroring,
    output logic [slbm_pkg::BANK_W-1:0]           prg_bank_low,
    output logic [slbm_pkg::BANK_W-1:0]           prg_bank_high,
    output logic [slbm_pkg::BANK_W-1:0]           chr_bank_low,
    output logic [slbm_pkg::BANK_W-1:0]           chr_bank_high,
    output logic [1:0]                            wram_bank,
    output logic                                  write_accepted,
    // Configuration port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [slbm_pkg::PADDR_W-1:0]     paddr,
    input  wire logic [slbm_pkg::PDATA_W-1:0]     pwdata,
    output logic      [slbm_pkg::PDATA_W-1:0]     prdata,
    output logic                                  pready
);

    slbm_pkg::cfg_t              cfg;
    slbm_pkg::result_t           res;
    slbm_pkg::result_t           out_reg;
    logic                        out_valid_reg;
    logic                        in_valid_reg;
    logic                        cmd_reg;
    logic [slbm_pkg::ADDR_W-1:0] addr_reg;
    logic [slbm_pkg::DATA_W-1:0] data_reg;
    logic                        out_free;
    logic                        advance;
    logic                        in_take;

    // Handshake control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg  <= cmd;
            addr_reg <= cpu_addr;
            data_reg <= wdata;
        end
    end

    slbm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slbm_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .cmd      (cmd_reg),
        .cpu_addr (addr_reg),
        .wdata    (data_reg),
        .cfg      (cfg),
        .res      (res)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign mirroring      = out_reg.mirroring;
    assign prg_bank_low   = out_reg.prg_bank_low;
    assign prg_bank_high  = out_reg.prg_bank_high;
    assign chr_bank_low   = out_reg.chr_bank_low;
    assign chr_bank_high  = out_reg.chr_bank_high;
    assign wram_bank      = out_reg.wram_bank;
    assign write_accepted = out_reg.write_accepted;

endmodule
`default_nettype wire

// File: rtl/slbm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slbm_checker
// Port-level checks of the bank mapper: reset, stall behavior and the
// minimum gap between accepted mapper writes.
// ----------------------------------------------------------------------------
module slbm_checker
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_stall,
    input  wire logic                             out_valid,
    input  wire logic                             out_stall,
    input  wire logic [1:0]                       mirroring,
    input  wire logic [slbm_pkg::BANK_W-1:0]      prg_bank_low,
    input  wire logic [slbm_pkg::BANK_W-1:0]      prg_bank_high,
    input  wire logic [slbm_pkg::BANK_W-1:0]      chr_bank_low,
    input  wire logic [slbm_pkg::BANK_W-1:0]      chr_bank_high,
    input  wire logic [1:0]                       wram_bank,
    input  wire logic                             write_accepted
);

    logic       out_xfer;
    logic [1:0] gap_reg;
    logic [1:0] gap_next;

    assign out_xfer = out_valid && !out_stall;

    // Count delivered transactions since reset or the last accepted write
    always_comb
    begin
        gap_next = gap_reg;
        if (out_xfer)
        begin
            if (write_accepted)
            begin
                gap_next = 2'd0;
            end
            else if (gap_reg < slbm_pkg::MIN_GAP)
            begin
                gap_next = gap_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_reg <= 2'd0;
        end
        else
        begin
            gap_reg <= gap_next;
        end
    end

    // No result is offered in the cycle after reset is applied
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(mirroring)
            && $stable(prg_bank_low) && $stable(prg_bank_high)
            && $stable(chr_bank_low) && $stable(chr_bank_high)
            && $stable(wram_bank) && $stable(write_accepted))
        else $error("stalled result changed");

    // Input back-pressure only comes from a stalled full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // An accepted write needs two non-accepting transactions before it
    a_write_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && write_accepted |-> gap_reg == slbm_pkg::MIN_GAP)
        else $error("mapper write accepted too soon");

endmodule

bind serial_loaded_bank_mapper_unit slbm_checker u_slbm_checker (.*);
`default_nettype wire
